[src/psm_pkg.sv]
package psm_pkg;

  localparam int WORD_W = 32;
  localparam int PC_W   = 11;
  localparam int IDX_W  = 9;
  localparam int KIND_W = 3;
  localparam int ERR_W  = 2;

  localparam logic [KIND_W-1:0] KIND_LIT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STO = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CAL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_INT = 3'd5;
  localparam logic [KIND_W-1:0] KIND_JMP = 3'd6;
  localparam logic [KIND_W-1:0] KIND_JPC = 3'd7;

  localparam logic [WORD_W-1:0] OPR_RET = 32'd0;
  localparam logic [WORD_W-1:0] OPR_NEG = 32'd1;
  localparam logic [WORD_W-1:0] OPR_ADD = 32'd2;
  localparam logic [WORD_W-1:0] OPR_SUB = 32'd3;
  localparam logic [WORD_W-1:0] OPR_MUL = 32'd4;
  localparam logic [WORD_W-1:0] OPR_DIV = 32'd5;
  localparam logic [WORD_W-1:0] OPR_ODD = 32'd6;
  localparam logic [WORD_W-1:0] OPR_EQ  = 32'd8;
  localparam logic [WORD_W-1:0] OPR_NE  = 32'd9;
  localparam logic [WORD_W-1:0] OPR_LT  = 32'd10;
  localparam logic [WORD_W-1:0] OPR_GE  = 32'd11;
  localparam logic [WORD_W-1:0] OPR_GT  = 32'd12;
  localparam logic [WORD_W-1:0] OPR_LE  = 32'd13;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OPC   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

endpackage

[src/psm_ifs.sv]
interface psm_in_if;
  logic                             valid;
  logic                             ready;
  logic [psm_pkg::KIND_W-1:0]       kind;
  logic signed [psm_pkg::WORD_W-1:0] operand;
  modport source (output valid, kind, operand, input ready);
  modport sink (input valid, kind, operand, output ready);
endinterface

interface psm_out_if;
  logic                              valid;
  logic                              ready;
  logic [psm_pkg::PC_W-1:0]          next_pc;
  logic [psm_pkg::IDX_W-1:0]         base;
  logic [psm_pkg::IDX_W-1:0]         top;
  logic signed [psm_pkg::WORD_W-1:0] top_value;
  logic [psm_pkg::ERR_W-1:0]         error;
  modport source (output valid, next_pc, base, top, top_value, error, input ready);
  modport sink (input valid, next_pc, base, top, top_value, error, output ready);
endinterface

[src/pcode_stack_machine_step_core.sv]
// An accepted word passes through decode, two stack reads, execute, write-back and
// finish before the result register is loaded; cal writes three link words, a divide
// waits on the divider first, and an error skips the write-back.
// One instruction at a time: the next word is accepted only after the result is
// loaded and the machine is back in idle.
// After reset the stack memory is cleared one word per cycle, and no instruction is
// accepted until that is done; pc is 0, base 1 and top 0.
module pcode_stack_machine_step_core #(
  parameter int STACK_DEPTH = 512
) (
  input  logic           clk,
  input  logic           rst,
  psm_in_if.sink         cmd,
  psm_out_if.source      rsp
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int SW = 34;
  localparam logic [IW-1:0] LAST = IW'(STACK_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_E = (IW+1)'(STACK_DEPTH);
  localparam logic signed [SW-1:0] DEPTH_S = SW'(STACK_DEPTH);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_DEC  = 10'b0000000100,
    S_A    = 10'b0000001000,
    S_B    = 10'b0000010000,
    S_EXE  = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_WB   = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state;
  logic [IW-1:0] clr_idx;
  logic [psm_pkg::PC_W-1:0] pc;
  logic [IW-1:0] base_r;
  logic [IW-1:0] top_r;
  logic [psm_pkg::KIND_W-1:0] kind_r;
  psm_pkg::word_t a_r;
  logic [psm_pkg::ERR_W-1:0] err_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_t_r;
  psm_pkg::word_t op_a;
  psm_pkg::word_t op_b;
  psm_pkg::word_t res;
  logic [1:0] wcnt;

  logic mem_we;
  logic [IW-1:0] mem_wa;
  psm_pkg::word_t mem_wd;
  logic mem_re;
  logic [IW-1:0] mem_ra;
  psm_pkg::word_t mem_rd;

  psm_pkg::div_req_t div_req;
  logic div_done;
  psm_pkg::word_t div_q;

  logic [IW:0] top_p1, top_p3, base_p1;
  logic signed [SW-1:0] idx_b, idx_t;
  logic idx_b_ok, idx_t_ok;
  logic is_ret, is_una, is_bin;
  logic [psm_pkg::ERR_W-1:0] dec_err;
  logic [IW-1:0] addr_a;
  psm_pkg::word_t alu;
  psm_pkg::word_t mag_a, mag_b;
  logic [psm_pkg::PC_W-1:0] pc_inc;
  logic [31:0] base_ext, top_ext;

  psm_stack #(.DEPTH(STACK_DEPTH), .AW(IW)) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  psm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_q)
  );

  assign pc_inc = pc + psm_pkg::PC_W'(1);
  assign base_ext = 32'(base_r);
  assign top_ext  = 32'(top_r);

  // Index arithmetic and range checks for the instruction being decoded.
  always_comb begin
    top_p1  = {1'b0, top_r} + (IW+1)'(1);
    top_p3  = {1'b0, top_r} + (IW+1)'(3);
    base_p1 = {1'b0, base_r} + (IW+1)'(1);
    idx_b = $signed({{(SW-IW){1'b0}}, base_r}) + $signed({{(SW-32){a_r[31]}}, a_r});
    idx_t = $signed({{(SW-IW){1'b0}}, top_r}) + $signed({{(SW-32){a_r[31]}}, a_r});
    idx_b_ok = (idx_b >= 0) && (idx_b < DEPTH_S);
    idx_t_ok = (idx_t >= 0) && (idx_t < DEPTH_S);
    is_ret = (a_r == psm_pkg::OPR_RET);
    is_una = (a_r == psm_pkg::OPR_NEG) || (a_r == psm_pkg::OPR_ODD);
    is_bin = (a_r == psm_pkg::OPR_ADD) || (a_r == psm_pkg::OPR_SUB) ||
             (a_r == psm_pkg::OPR_MUL) || (a_r == psm_pkg::OPR_DIV) ||
             (a_r == psm_pkg::OPR_EQ)  || (a_r == psm_pkg::OPR_NE)  ||
             (a_r == psm_pkg::OPR_LT)  || (a_r == psm_pkg::OPR_GE)  ||
             (a_r == psm_pkg::OPR_GT)  || (a_r == psm_pkg::OPR_LE);
    dec_err = psm_pkg::ERR_OK;
    addr_a  = top_r;
    case (kind_r)
      psm_pkg::KIND_LIT: begin
        if (top_p1 >= DEPTH_E) dec_err = psm_pkg::ERR_RANGE;
      end
      psm_pkg::KIND_OPR: begin
        if (is_ret) begin
          addr_a = base_r;
          if (base_r == '0 || base_p1 >= DEPTH_E) dec_err = psm_pkg::ERR_RANGE;
        end else if (!is_una) begin
          addr_a = top_r - IW'(1);
          if (top_r == '0) dec_err = psm_pkg::ERR_RANGE;
          else if (!is_bin) dec_err = psm_pkg::ERR_OPC;
        end
      end
      psm_pkg::KIND_LOD: begin
        addr_a = idx_b[IW-1:0];
        if (!idx_b_ok || top_p1 >= DEPTH_E) dec_err = psm_pkg::ERR_RANGE;
      end
      psm_pkg::KIND_STO: begin
        if (!idx_b_ok || top_r == '0) dec_err = psm_pkg::ERR_RANGE;
      end
      psm_pkg::KIND_CAL: begin
        if (top_p3 >= DEPTH_E) dec_err = psm_pkg::ERR_RANGE;
      end
      psm_pkg::KIND_INT: begin
        if (!idx_t_ok) dec_err = psm_pkg::ERR_RANGE;
      end
      psm_pkg::KIND_JPC: begin
        if (top_r == '0) dec_err = psm_pkg::ERR_RANGE;
      end
      default: ;
    endcase
  end

  // Shared arithmetic unit: op_a is the lower word (or the only one), op_b the top.
  always_comb begin
    mag_a = op_a[31] ? (32'd0 - op_a) : op_a;
    mag_b = op_b[31] ? (32'd0 - op_b) : op_b;
    case (a_r)
      psm_pkg::OPR_NEG: alu = 32'd0 - op_a;
      psm_pkg::OPR_ODD: alu = op_a[0] ? (op_a[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
      psm_pkg::OPR_ADD: alu = op_a + op_b;
      psm_pkg::OPR_SUB: alu = op_a - op_b;
      psm_pkg::OPR_MUL: alu = op_a * op_b;
      psm_pkg::OPR_EQ:  alu = 32'(op_a == op_b);
      psm_pkg::OPR_NE:  alu = 32'(op_a != op_b);
      psm_pkg::OPR_LT:  alu = 32'($signed(op_a) < $signed(op_b));
      psm_pkg::OPR_GE:  alu = 32'($signed(op_a) >= $signed(op_b));
      psm_pkg::OPR_GT:  alu = 32'($signed(op_a) > $signed(op_b));
      psm_pkg::OPR_LE:  alu = 32'($signed(op_a) <= $signed(op_b));
      default:          alu = '0;
    endcase
    div_req.start = (state == S_EXE) && (err_r == psm_pkg::ERR_OK) &&
                    (kind_r == psm_pkg::KIND_OPR) && (a_r == psm_pkg::OPR_DIV) &&
                    (op_b != '0);
    div_req.num = mag_a;
    div_req.den = mag_b;
  end

  // Stack memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = top_r;
    mem_wd = res;
    mem_re = 1'b0;
    mem_ra = top_r;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = '0;
      end
      S_DEC: begin
        mem_re = 1'b1;
        mem_ra = addr_a;
      end
      S_A: begin
        mem_re = 1'b1;
        mem_ra = is_ret ? base_p1[IW-1:0] : top_r;
      end
      S_FIN: begin
        mem_re = 1'b1;
        mem_ra = top_r;
      end
      S_WB: begin
        case (kind_r)
          psm_pkg::KIND_LIT: begin
            mem_we = 1'b1;
            mem_wa = top_p1[IW-1:0];
            mem_wd = a_r;
          end
          psm_pkg::KIND_OPR: begin
            mem_we = !is_ret;
            mem_wa = is_una ? top_r : top_r - IW'(1);
            mem_wd = res;
          end
          psm_pkg::KIND_LOD: begin
            mem_we = 1'b1;
            mem_wa = top_p1[IW-1:0];
            mem_wd = op_a;
          end
          psm_pkg::KIND_STO: begin
            mem_we = 1'b1;
            mem_wa = idx_r;
            mem_wd = op_a;
          end
          psm_pkg::KIND_CAL: begin
            // Frame link words: old base, return address, then the target.
            mem_we = 1'b1;
            mem_wa = top_p1[IW-1:0] + IW'(wcnt);
            case (wcnt)
              2'd0:    mem_wd = base_ext;
              2'd1:    mem_wd = 32'(pc_inc);
              default: mem_wd = a_r;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      pc        <= '0;
      base_r    <= IW'(1);
      top_r     <= '0;
      rsp.valid <= 1'b0;
      err_r     <= psm_pkg::ERR_OK;
      wcnt      <= '0;
    end else begin
      // In S_OUT the valid flag is handled by the state itself.
      if (rsp.valid && rsp.ready && state != S_OUT) rsp.valid <= 1'b0;
      case (state)
        S_CLR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.valid) begin
            kind_r <= cmd.kind;
            a_r    <= cmd.operand;
            wcnt   <= '0;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          err_r   <= dec_err;
          idx_r   <= idx_b[IW-1:0];
          idx_t_r <= idx_t[IW-1:0];
          state   <= S_A;
        end
        S_A: begin
          op_a  <= mem_rd;
          state <= S_B;
        end
        S_B: begin
          if (kind_r == psm_pkg::KIND_OPR && !is_una) op_b <= mem_rd;
          else op_b <= op_a;
          state <= S_EXE;
        end
        S_EXE: begin
          res <= alu;
          if (err_r != psm_pkg::ERR_OK) begin
            state <= S_FIN;
          end else if (kind_r == psm_pkg::KIND_OPR && a_r == psm_pkg::OPR_DIV) begin
            if (op_b == '0) begin
              err_r <= psm_pkg::ERR_DIV0;
              state <= S_FIN;
            end else begin
              state <= S_DIV;
            end
          end else if (kind_r == psm_pkg::KIND_OPR && is_ret &&
                       op_a >= 32'(STACK_DEPTH)) begin
            err_r <= psm_pkg::ERR_RANGE;
            state <= S_FIN;
          end else begin
            state <= S_WB;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res   <= (op_a[31] ^ op_b[31]) ? (32'd0 - div_q) : div_q;
            state <= S_WB;
          end
        end
        S_WB: begin
          if (kind_r == psm_pkg::KIND_CAL && wcnt != 2'd2) begin
            wcnt <= wcnt + 2'd1;
          end else begin
            case (kind_r)
              psm_pkg::KIND_LIT, psm_pkg::KIND_LOD: begin
                top_r <= top_p1[IW-1:0];
                pc    <= pc_inc;
              end
              psm_pkg::KIND_OPR: begin
                if (is_ret) begin
                  pc     <= op_b[psm_pkg::PC_W-1:0];
                  top_r  <= base_r - IW'(1);
                  base_r <= op_a[IW-1:0];
                end else begin
                  pc <= pc_inc;
                  if (!is_una) top_r <= top_r - IW'(1);
                end
              end
              psm_pkg::KIND_STO: begin
                top_r <= top_r - IW'(1);
                pc    <= pc_inc;
              end
              psm_pkg::KIND_CAL: begin
                base_r <= top_p1[IW-1:0];
                pc     <= a_r[psm_pkg::PC_W-1:0];
              end
              psm_pkg::KIND_INT: begin
                top_r <= idx_t_r;
                pc    <= pc_inc;
              end
              psm_pkg::KIND_JMP: pc <= a_r[psm_pkg::PC_W-1:0];
              psm_pkg::KIND_JPC: begin
                top_r <= top_r - IW'(1);
                pc    <= (op_a == '0) ? a_r[psm_pkg::PC_W-1:0] : pc_inc;
              end
              default: pc <= pc_inc;
            endcase
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result word payload; loaded together with the valid flag.
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp.valid || rsp.ready)) begin
      rsp.next_pc   <= pc;
      rsp.base      <= base_ext[psm_pkg::IDX_W-1:0];
      rsp.top       <= top_ext[psm_pkg::IDX_W-1:0];
      rsp.top_value <= mem_rd;
      rsp.error     <= err_r;
    end
  end

  assign cmd.ready = (state == S_IDLE);

endmodule

[src/psm_stack.sv]
module psm_stack #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  psm_pkg::word_t      wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output psm_pkg::word_t      rdata
);

  psm_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/psm_div.sv]
module psm_div (
  input  logic              clk,
  input  logic              rst,
  input  psm_pkg::div_req_t req,
  output logic              done,
  output psm_pkg::word_t    quo
);

  logic        busy;
  logic [4:0]  cnt;
  psm_pkg::word_t rem;
  psm_pkg::word_t den;
  logic [32:0] shifted;
  logic [32:0] diff;

  // One restoring step per cycle: shift in the next dividend bit, try the subtract.
  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule
